>>> hw/rtl/serial_header_packet_deframer_assert.svh
// Assertion macros for the serial deframer.
// Each use names a label, a condition and a consequence, sampled on clock
// and disabled while reset is high.
`ifndef SERIAL_HEADER_PACKET_DEFRAMER_ASSERT_SVH
`define SERIAL_HEADER_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication
`define SHDF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("serial deframer check failed");

// Next-cycle implication
`define SHDF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("serial deframer check failed");

`endif

>>> hw/rtl/shdf_pkg.sv
package shdf_pkg;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_SYNC   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_WORD   = 2'd2
   } kind_type;

   // Deframer phase
   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   // Register map
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_PATTERN = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT_LSB    = 2'd1;

   // Count field position register
   localparam int LSB_BITS = 6;
   localparam logic [LSB_BITS-1:0] COUNT_LSB_RESET = 6'd10;

   // Per-bit status from the deframer core
   typedef struct packed {
      logic     emit;
      kind_type kind;
      logic     last;
   } core_status_type;

endpackage

>>> hw/rtl/shdf_ifs.sv
// Serial bit input channel
interface shdf_req_if;
   logic valid;
   logic ready;
   logic serial_bit;
   modport source (output valid, output serial_bit, input ready);
   modport sink (input valid, input serial_bit, output ready);
endinterface

// Result channel
interface shdf_rsp_if #(
   parameter int HEADER_BITS = 50,
   parameter int WORD_BITS   = 10,
   parameter int COUNT_BITS  = 10
);
   logic                     valid;
   logic                     ready;
   shdf_pkg::kind_type       kind;
   logic [HEADER_BITS-1:0]   header;
   logic [COUNT_BITS-1:0]    payload_words;
   logic [WORD_BITS-1:0]     data_word;
   logic                     last;
   modport source (output valid, output kind, output header, output payload_words,
                   output data_word, output last, input ready);
   modport sink (input valid, input kind, input header, input payload_words,
                 input data_word, input last, output ready);
endinterface

// Register write channel
interface shdf_csr_if #(
   parameter int DATA_BITS = 50
);
   logic                                valid;
   logic                                ready;
   logic [shdf_pkg::CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]                data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/shdf_core.sv
module shdf_core #(
   parameter int HEADER_BITS = 50,
   parameter int WORD_BITS   = 10,
   parameter int COUNT_BITS  = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          serial_bit,
   input  logic [HEADER_BITS-1:0]        sync_pattern,
   input  logic [shdf_pkg::LSB_BITS-1:0] count_lsb,
   output shdf_pkg::core_status_type     status,
   output logic [HEADER_BITS-1:0]        res_header,
   output logic [COUNT_BITS-1:0]         res_words,
   output logic [WORD_BITS-1:0]          res_data
);

   localparam int LEFT_BITS = $clog2(HEADER_BITS + 1);
   localparam int POS_BITS  = $clog2(WORD_BITS + 1);
   localparam int EXT_BITS  = HEADER_BITS + COUNT_BITS;

   shdf_pkg::phase_type     phase_ff, phase_in;
   logic [HEADER_BITS-1:0]  header_ff, header_in;
   logic [LEFT_BITS-1:0]    left_ff, left_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [WORD_BITS-1:0]    word_ff, word_in;
   logic [COUNT_BITS-1:0]   rcvd_ff, rcvd_in;
   logic [COUNT_BITS-1:0]   len_ff, len_in;

   logic [HEADER_BITS-1:0]  shifted;
   logic [EXT_BITS-1:0]     count_ext;
   logic [COUNT_BITS-1:0]   count;
   logic [WORD_BITS-1:0]    acc;
   logic [COUNT_BITS-1:0]   rcvd_next;

   // Window shifts right, new bit enters at the top
   assign shifted   = {serial_bit, header_ff[HEADER_BITS-1:1]};
   // Count field; bits above the header read as zero
   assign count_ext = {{COUNT_BITS{1'b0}}, shifted} >> count_lsb;
   assign count     = count_ext[COUNT_BITS-1:0];
   assign acc       = word_ff | (WORD_BITS'(serial_bit) << pos_ff);
   assign rcvd_next = rcvd_ff + COUNT_BITS'(1);

   // Next state and result for the bit in hand
   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      word_in    = word_ff;
      rcvd_in    = rcvd_ff;
      len_in     = len_ff;
      status     = '{emit: 1'b0, kind: shdf_pkg::KIND_SYNC, last: 1'b0};
      res_header = shifted;
      res_words  = '0;
      res_data   = '0;
      unique case (phase_ff)
         shdf_pkg::PHASE_HUNT: begin
            header_in = shifted;
            if (shifted == sync_pattern) begin
               status.emit = 1'b1;
               phase_in    = shdf_pkg::PHASE_HEADER;
               left_in     = LEFT_BITS'(HEADER_BITS);
            end
         end
         shdf_pkg::PHASE_HEADER: begin
            header_in = shifted;
            left_in   = left_ff - LEFT_BITS'(1);
            if (left_ff == LEFT_BITS'(1)) begin
               len_in      = count;
               status.emit = 1'b1;
               status.kind = shdf_pkg::KIND_HEADER;
               res_words   = count;
               if (count == '0) begin
                  // Empty packet: straight into the next header
                  left_in     = LEFT_BITS'(HEADER_BITS);
                  status.last = 1'b1;
               end else begin
                  phase_in = shdf_pkg::PHASE_PAYLOAD;
                  word_in  = '0;
                  pos_in   = '0;
                  rcvd_in  = '0;
               end
            end
         end
         shdf_pkg::PHASE_PAYLOAD: begin
            res_header = header_ff;
            word_in    = acc;
            pos_in     = pos_ff + POS_BITS'(1);
            if (pos_ff == POS_BITS'(WORD_BITS - 1)) begin
               status.emit = 1'b1;
               status.kind = shdf_pkg::KIND_WORD;
               res_words   = len_ff;
               res_data    = acc;
               word_in     = '0;
               pos_in      = '0;
               rcvd_in     = rcvd_next;
               if (rcvd_next == len_ff) begin
                  status.last = 1'b1;
                  phase_in    = shdf_pkg::PHASE_HEADER;
                  left_in     = LEFT_BITS'(HEADER_BITS);
               end
            end
         end
         default: begin
            phase_in = shdf_pkg::PHASE_HUNT;
         end
      endcase
   end

   // Advance state on each consumed bit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= shdf_pkg::PHASE_HUNT;
         header_ff <= '0;
         left_ff   <= '0;
         pos_ff    <= '0;
         word_ff   <= '0;
         rcvd_ff   <= '0;
         len_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         word_ff   <= word_in;
         rcvd_ff   <= rcvd_in;
         len_ff    <= len_in;
      end
   end

endmodule

>>> hw/rtl/serial_header_packet_deframer.sv
// Channel   Dir  Transfer carries
// req_chan  in   serial_bit, one link bit, LSB first
// rsp_chan  out  kind, header, payload_words, data_word, last
// csr_chan  in   index, data (0 sync pattern, 1 count field position)
//
// One bit is taken every cycle unless a full result register stalls it (see
// below); a result comes through the input register, then the result register.
// The input register keeps taking bits while a result waits, until a bit
// that would make a second result finds the result register still full.
// Reset is synchronous: the link goes back to hunting for the sync header.
`include "serial_header_packet_deframer_assert.svh"

module serial_header_packet_deframer #(
   parameter int HEADER_BITS = 50,
   parameter int WORD_BITS   = 10,
   parameter int COUNT_BITS  = 10
) (
   input logic        clock,
   input logic        reset,
   shdf_req_if.sink   req_chan,
   shdf_rsp_if.source rsp_chan,
   shdf_csr_if.sink   csr_chan
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_bit_ff;
   logic                          out_valid_ff, out_valid_in;
   shdf_pkg::kind_type            out_kind_ff;
   logic [HEADER_BITS-1:0]        out_header_ff;
   logic [COUNT_BITS-1:0]         out_words_ff;
   logic [WORD_BITS-1:0]          out_data_ff;
   logic                          out_last_ff;
   logic [HEADER_BITS-1:0]        sync_ff;
   logic [shdf_pkg::LSB_BITS-1:0] lsb_ff;

   shdf_pkg::core_status_type     status;
   logic [HEADER_BITS-1:0]        res_header;
   logic [COUNT_BITS-1:0]         res_words;
   logic [WORD_BITS-1:0]          res_data;
   logic                          advance;
   logic                          load_out;

   // Consume the held bit unless its result has nowhere to go
   assign advance  = in_valid_ff && (!status.emit || !out_valid_ff || rsp_chan.ready);
   assign load_out = advance && status.emit;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   shdf_core #(
      .HEADER_BITS(HEADER_BITS),
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .serial_bit  (in_bit_ff),
      .sync_pattern(sync_ff),
      .count_lsb   (lsb_ff),
      .status      (status),
      .res_header  (res_header),
      .res_words   (res_words),
      .res_data    (res_data)
   );

   // Input register occupancy
   always_comb begin
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Result register occupancy
   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming bit
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_bit_ff <= req_chan.serial_bit;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff   <= status.kind;
         out_header_ff <= res_header;
         out_words_ff  <= res_words;
         out_data_ff   <= res_data;
         out_last_ff   <= status.last;
      end
   end

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= '0;
         lsb_ff  <= shdf_pkg::COUNT_LSB_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            shdf_pkg::CSR_SYNC_PATTERN: sync_ff <= csr_chan.data[HEADER_BITS-1:0];
            shdf_pkg::CSR_COUNT_LSB:    lsb_ff  <= csr_chan.data[shdf_pkg::LSB_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.header        = out_header_ff;
   assign rsp_chan.payload_words = out_words_ff;
   assign rsp_chan.data_word     = out_data_ff;
   assign rsp_chan.last          = out_last_ff;

   `SHDF_ASSERT_NOW(a_no_overwrite, out_valid_ff && !rsp_chan.ready, !load_out)
   `SHDF_ASSERT_NEXT(a_result_lands, load_out,
      rsp_chan.valid && rsp_chan.kind == $past(status.kind))
   `SHDF_ASSERT_NOW(a_sync_clean, rsp_chan.valid && rsp_chan.kind == shdf_pkg::KIND_SYNC,
      !rsp_chan.last && rsp_chan.payload_words == '0 && rsp_chan.data_word == '0)
   `SHDF_ASSERT_NOW(a_empty_header,
      rsp_chan.valid && rsp_chan.kind == shdf_pkg::KIND_HEADER && rsp_chan.last,
      rsp_chan.payload_words == '0)

endmodule
